// ----- hw/rtl/dqsa_pkg.sv -----
// Shared constants and types for the two-queue shared word store.
package dqsa_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  // Operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Queue select codes
  localparam logic QUEUE_LOWER = 1'b0;
  localparam logic QUEUE_UPPER = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;    // input transfer: update pointers, access store
    logic capture;  // store read data is valid: latch pop word
  } ctl_cmd_t;

endpackage

// ----- hw/rtl/dual_queue_shared_array.sv -----
// Top level of two linear queues that share one word store.
// Two linear queues share one store of DEPTH words: the lower queue grows up
// from entry 0, the upper queue grows down from the top entry. Each input
// transfer is a push or a pop aimed at one queue and yields exactly one result
// transfer carrying the popped word (zero unless a pop succeeded), a status
// (done, overflow, underflow) and the full and empty flags after the operation.
// A push to either queue is refused when the two tails meet; head space freed
// by pops is reused only once a queue drains completely. One item is handled
// at a time: after the input transfer the controller passes through accept and
// pointer update, registered store read and result hold, and the result stays
// valid in the hold state until it transfers; only then is the next input
// transfer accepted, so any output stall delays it. This order is set by the
// registered read port of the store and the single-item controller.
// The store needs no clearing after reset; a pop only reads written entries.
module dual_queue_shared_array (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic                               in_queue_select,
  input  logic signed [dqsa_pkg::WORD_W-1:0] in_push_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dqsa_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                         out_status,
  output logic                               out_shared_full,
  output logic                               out_first_empty,
  output logic                               out_second_empty
);
  import dqsa_pkg::*;

  ctl_cmd_t cmd;

  dqsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dqsa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_queue_select  (in_queue_select),
    .in_push_value    (in_push_value),
    .out_pop_value    (out_pop_value),
    .out_status       (out_status),
    .out_shared_full  (out_shared_full),
    .out_first_empty  (out_first_empty),
    .out_second_empty (out_second_empty)
  );

endmodule

// ----- hw/rtl/dqsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dqsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/dqsa_ctrl.sv -----
// Controller state machine: sequences accept, store read and result transfer.
module dqsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output dqsa_pkg::ctl_cmd_t  cmd
);
  import dqsa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SEND  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Take an item only while idle; show the result while sending
  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = (state_r == ST_SEND);
  assign cmd.start   = (state_r == ST_IDLE) && in_valid;
  assign cmd.capture = (state_r == ST_FETCH);

  // Advance through accept, fetch and send
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/dqsa_dp.sv -----
// Datapath: queue pointers, shared word store and result registers.
module dqsa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dqsa_pkg::ctl_cmd_t                cmd,
  input  logic                              in_func,
  input  logic                              in_queue_select,
  input  logic signed [dqsa_pkg::WORD_W-1:0] in_push_value,
  output logic signed [dqsa_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                        out_status,
  output logic                              out_shared_full,
  output logic                              out_first_empty,
  output logic                              out_second_empty
);
  import dqsa_pkg::*;

  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
  localparam logic [PTR_W-1:0] PTR_ZERO  = '0;

  // Lower pointers held as index plus one, so zero means empty
  logic [PTR_W-1:0] lt1_r, lt1_nxt;
  logic [PTR_W-1:0] lh1_r, lh1_nxt;
  // Upper pointers held as plain index, DEPTH means empty
  logic [PTR_W-1:0] ut_r, ut_nxt;
  logic [PTR_W-1:0] uh_r, uh_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] lower_rd_addr;
  logic [ADDR_W-1:0] upper_wr_addr;
  logic [WORD_W-1:0] rd_data;
  logic [1:0]        status_nxt;
  logic              pop_ok_nxt;

  logic [1:0]        status_r;
  logic              pop_ok_r;
  logic              full_r;
  logic              first_empty_r;
  logic              second_empty_r;
  logic [WORD_W-1:0] pop_value_r;

  logic [PTR_W-1:0]  lh1_dec;
  logic [PTR_W-1:0]  ut_dec;

  assign lh1_dec       = lh1_r - PTR_ONE;
  assign ut_dec        = ut_r - PTR_ONE;
  assign lower_rd_addr = lh1_dec[ADDR_W-1:0];
  assign upper_wr_addr = ut_dec[ADDR_W-1:0];
  assign rd_addr       = (in_queue_select == QUEUE_LOWER) ? lower_rd_addr
                                                          : uh_r[ADDR_W-1:0];
  assign wr_addr       = (in_queue_select == QUEUE_LOWER) ? lt1_r[ADDR_W-1:0]
                                                          : upper_wr_addr;

  // Decode the operation and compute next pointers
  always_comb begin
    lt1_nxt    = lt1_r;
    lh1_nxt    = lh1_r;
    ut_nxt     = ut_r;
    uh_nxt     = uh_r;
    wr_en      = 1'b0;
    status_nxt = STATUS_DONE;
    pop_ok_nxt = 1'b0;
    if (cmd.start) begin
      if (in_func == FUNC_PUSH) begin
        if (lt1_r == ut_r) begin
          status_nxt = STATUS_OVERFLOW;
        end else if (in_queue_select == QUEUE_LOWER) begin
          wr_en   = 1'b1;
          lt1_nxt = lt1_r + PTR_ONE;
          if (lt1_r == PTR_ZERO) lh1_nxt = PTR_ONE;
        end else begin
          wr_en  = 1'b1;
          ut_nxt = ut_dec;
          if (ut_r == PTR_DEPTH) uh_nxt = ut_dec;
        end
      end else begin
        if (in_queue_select == QUEUE_LOWER) begin
          if (lh1_r == PTR_ZERO) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            pop_ok_nxt = 1'b1;
            if (lh1_r == lt1_r) begin
              lh1_nxt = PTR_ZERO;
              lt1_nxt = PTR_ZERO;
            end else begin
              lh1_nxt = lh1_r + PTR_ONE;
            end
          end
        end else begin
          if (uh_r == PTR_DEPTH) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            pop_ok_nxt = 1'b1;
            if (uh_r == ut_r) begin
              uh_nxt = PTR_DEPTH;
              ut_nxt = PTR_DEPTH;
            end else begin
              uh_nxt = uh_r - PTR_ONE;
            end
          end
        end
      end
    end
  end

  // Hold queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt1_r <= PTR_ZERO;
      lh1_r <= PTR_ZERO;
      ut_r  <= PTR_DEPTH;
      uh_r  <= PTR_DEPTH;
    end else begin
      lt1_r <= lt1_nxt;
      lh1_r <= lh1_nxt;
      ut_r  <= ut_nxt;
      uh_r  <= uh_nxt;
    end
  end

  // Latch status and flags at the input transfer, pop word in the cycle after it
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      status_r       <= status_nxt;
      pop_ok_r       <= pop_ok_nxt;
      full_r         <= (lt1_nxt == ut_nxt);
      first_empty_r  <= (lh1_nxt == PTR_ZERO);
      second_empty_r <= (uh_nxt == PTR_DEPTH);
    end
    if (cmd.capture) begin
      pop_value_r <= pop_ok_r ? rd_data : '0;
    end
  end

  dqsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_push_value),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign out_pop_value    = pop_value_r;
  assign out_status       = status_r;
  assign out_shared_full  = full_r;
  assign out_first_empty  = first_empty_r;
  assign out_second_empty = second_empty_r;

endmodule

// ----- tb/dual_queue_shared_array_tb.sv -----
// Self-checking testbench for the two-queue shared word store.
module dual_queue_shared_array_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqsa_pkg::*;

  localparam int LOW_EMPTY       = -1;
  localparam int ITEMS_PER_PHASE = 417;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [WORD_W-1:0] pop_word;
    logic [1:0]        status;
    logic              full;
    logic              low_empty;
    logic              up_empty;
  } queue_result_t;

  typedef struct packed {
    logic              func;
    logic              sel;
    logic [WORD_W-1:0] word;
    logic              typed;
    queue_result_t     want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_func;
  logic in_queue_select;
  logic signed [WORD_W-1:0] in_push_value;
  logic out_valid;
  logic out_stall;
  logic signed [WORD_W-1:0] out_pop_value;
  logic [1:0] out_status;
  logic out_shared_full;
  logic out_first_empty;
  logic out_second_empty;

  // Shadow of the queue pointers and the word store
  int low_head;
  int low_tail;
  int up_head;
  int up_tail;
  logic [WORD_W-1:0] shadow_store [DEPTH];

  queue_result_t expected_results[$];
  op_row_t       directed_ops[$];
  int            mismatch_count = 0;
  int            sender_idle_pct;
  int            receiver_idle_pct;
  bit            hold_pending = 1'b0;

  dual_queue_shared_array u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_queue_select  (in_queue_select),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pop_value    (out_pop_value),
    .out_status       (out_status),
    .out_shared_full  (out_shared_full),
    .out_first_empty  (out_first_empty),
    .out_second_empty (out_second_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one push or pop to the shadow queues and return its result
  function automatic queue_result_t predict_step(input logic op, input logic which,
                                                 input logic [WORD_W-1:0] word);
    queue_result_t r;
    r = '0;
    r.status = STATUS_DONE;
    if (op == FUNC_PUSH) begin
      if (low_tail + 1 == up_tail) begin
        r.status = STATUS_OVERFLOW;
      end else if (which == QUEUE_LOWER) begin
        if (low_tail == LOW_EMPTY) begin
          low_head = 0;
          low_tail = 0;
        end else begin
          low_tail++;
        end
        shadow_store[low_tail] = word;
      end else begin
        if (up_tail == DEPTH) begin
          up_head = DEPTH - 1;
          up_tail = DEPTH - 1;
        end else begin
          up_tail--;
        end
        shadow_store[up_tail] = word;
      end
    end else if (which == QUEUE_LOWER) begin
      if (low_head == LOW_EMPTY) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        r.pop_word = shadow_store[low_head];
        // drain resets both pointers
        if (low_head == low_tail) begin
          low_head = LOW_EMPTY;
          low_tail = LOW_EMPTY;
        end else begin
          low_head++;
        end
      end
    end else begin
      if (up_head == DEPTH) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        r.pop_word = shadow_store[up_head];
        if (up_head == up_tail) begin
          up_head = DEPTH;
          up_tail = DEPTH;
        end else begin
          up_head--;
        end
      end
    end
    r.full      = (low_tail + 1 == up_tail);
    r.low_empty = (low_head == LOW_EMPTY);
    r.up_empty  = (up_head == DEPTH);
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its expectation
  task automatic send_op(input logic op, input logic which, input logic [WORD_W-1:0] word,
                         input logic typed, input queue_result_t want);
    queue_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= op;
    in_queue_select <= which;
    in_push_value   <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_step(op, which, word);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_monitor
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, pop %h status %0d", $time, out_pop_value,
                 out_status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("pop_value", want.pop_word, out_pop_value);
        check_field("status", WORD_W'(want.status), WORD_W'(out_status));
        check_field("shared_full", WORD_W'(want.full), WORD_W'(out_shared_full));
        check_field("first_empty", WORD_W'(want.low_empty), WORD_W'(out_first_empty));
        check_field("second_empty", WORD_W'(want.up_empty), WORD_W'(out_second_empty));
      end
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin : sender
    logic [WORD_W-1:0] fill_word;
    logic op_func;
    logic op_sel;
    int sent;
    int burst_len;
    int push_pct;
    op_row_t row;

    sender_idle_pct   = 23;
    receiver_idle_pct = 78;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_PUSH;
    in_queue_select <= QUEUE_LOWER;
    in_push_value   <= '0;
    low_head = LOW_EMPTY;
    low_tail = LOW_EMPTY;
    up_head  = DEPTH;
    up_tail  = DEPTH;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    // Directed table: underflow after reset, extremes, drain, fill, overflow
    directed_ops.push_back('{FUNC_POP, QUEUE_LOWER, 32'h0, 1'b1,
                             '{32'h0, STATUS_UNDERFLOW, 1'b0, 1'b1, 1'b1}});
    directed_ops.push_back('{FUNC_POP, QUEUE_UPPER, 32'h0, 1'b1,
                             '{32'h0, STATUS_UNDERFLOW, 1'b0, 1'b1, 1'b1}});
    directed_ops.push_back('{FUNC_PUSH, QUEUE_LOWER, 32'h7FFF_FFFF, 1'b1,
                             '{32'h0, STATUS_DONE, 1'b0, 1'b0, 1'b1}});
    directed_ops.push_back('{FUNC_PUSH, QUEUE_UPPER, 32'h8000_0000, 1'b1,
                             '{32'h0, STATUS_DONE, 1'b0, 1'b0, 1'b0}});
    directed_ops.push_back('{FUNC_POP, QUEUE_LOWER, 32'hFFFF_FFFF, 1'b1,
                             '{32'h7FFF_FFFF, STATUS_DONE, 1'b0, 1'b1, 1'b0}});
    directed_ops.push_back('{FUNC_POP, QUEUE_UPPER, 32'h0, 1'b1,
                             '{32'h8000_0000, STATUS_DONE, 1'b0, 1'b1, 1'b1}});
    for (int i = 0; i < DEPTH; i++) begin
      fill_word = (i % 2) ? ~(32'h1111_1111 * i) : 32'h1111_1111 * i;
      directed_ops.push_back('{FUNC_PUSH, logic'(i % 2), fill_word, 1'b0, '0});
    end
    directed_ops.push_back('{FUNC_PUSH, QUEUE_LOWER, 32'h0, 1'b1,
                             '{32'h0, STATUS_OVERFLOW, 1'b1, 1'b0, 1'b0}});
    directed_ops.push_back('{FUNC_PUSH, QUEUE_UPPER, 32'hFFFF_FFFF, 1'b1,
                             '{32'h0, STATUS_OVERFLOW, 1'b1, 1'b0, 1'b0}});
    directed_ops.push_back('{FUNC_POP, QUEUE_LOWER, 32'h0, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      row = directed_ops[i];
      send_op(row.func, row.sel, row.word, row.typed, row.want);
    end

    // Random bursts, push-heavy, balanced or pop-heavy, to reach full and empty often
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct   = 23;
          receiver_idle_pct = 78;
        end
        1: begin
          sender_idle_pct   = 78;
          receiver_idle_pct = 23;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          hold_pending      = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst_len = $urandom_range(40, 4);
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
        for (int k = 0; k < burst_len && sent < ITEMS_PER_PHASE; k++) begin
          op_func = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
          op_sel  = $urandom_range(1) ? QUEUE_UPPER : QUEUE_LOWER;
          send_op(op_func, op_sel, $urandom(), 1'b0, '0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then keep watching for stray results
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
